FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define DQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked at every rising clock edge outside reset
`define DQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: sv/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// shared types and constants of the double ended queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

	localparam int DQ_DEPTH = 64;
	localparam int WORD_W   = 32;
	localparam int ACTION_W = 3;

	localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd4;

	typedef logic signed [WORD_W-1:0] word_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic  push_front;
		logic  push_back;
		logic  pop_front;
		logic  pop_back;
		logic  clear;
		word_t value;
	} dq_op_t;

endpackage

`default_nettype wire

FILE: sv/dq_ifs.sv
// ----------------------------------------------------------------------------
// dq_ifs
// valid / ready channels of the double ended queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dq_req_if;
	import dq_pkg::*;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	word_t               value;

	modport source (output valid, output action, output value, input ready);
	modport sink   (input valid, input action, input value, output ready);
endinterface

interface dq_rsp_if #(
	parameter int COUNT_W = 7
);
	import dq_pkg::*;
	logic               valid;
	logic               ready;
	word_t              front_value;
	word_t              back_value;
	logic [COUNT_W-1:0] count;
	logic               refused;

	modport source (output valid, output front_value, output back_value, output count,
		output refused, input ready);
	modport sink   (input valid, input front_value, input back_value, input count,
		input refused, output ready);
endinterface

`default_nettype wire

FILE: sv/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded deque of signed words built as a shifting chain of cells
// ----------------------------------------------------------------------------
// usage
//   req carries one action (push front, push back, pop front, pop back, clear)
//   and a word; every transfer on req gives exactly one transfer on rsp with
//   the front and back words (0 when empty), the count and the refused flag
//   the queue lives in DEPTH cells; each cell keeps the words in front order
//   and in back order, so both ends sit in cell 0 and a push or pop shifts
//   the chain by one cell
//   the result is registered and valid in the cycle after the req transfer
//   throughput: one action per cycle while rsp is taken; the state registers
//   are the result register, so req.ready is low only while a result waits
//   when rsp stalls, the result holds and req waits until it is taken
//   pop on an empty queue changes nothing; push on a full queue is dropped
//   and refused is set; unused action codes change nothing
//   reset empties the queue and drops any pending result; no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module double_ended_queue
	import dq_pkg::*;
#(
	parameter int DEPTH   = DQ_DEPTH,
	parameter int COUNT_W = $clog2(DEPTH + 1)
) (
	input wire logic clk,
	input wire logic arst_n,
	dq_req_if.sink   req,
	dq_rsp_if.source rsp
);

	dq_op_t             op;
	logic               accept;
	logic               full;
	logic               empty;
	logic               rsp_valid_q;
	logic               refused_q;
	logic [COUNT_W-1:0] count_q;
	word_t              f_vec [DEPTH];
	word_t              r_vec [DEPTH];
	logic [DEPTH-1:0]   valid_vec;

	assign accept    = req.valid && req.ready;
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign full      = (count_q == COUNT_W'(DEPTH));
	assign empty     = (count_q == '0);

	always_comb begin
		op       = '0;
		op.value = req.value;
		if (accept) begin
			unique case (req.action)
				ACT_PUSH_FRONT: op.push_front = !full;
				ACT_PUSH_BACK:  op.push_back  = !full;
				ACT_POP_FRONT:  op.pop_front  = !empty;
				ACT_POP_BACK:   op.pop_back   = !empty;
				ACT_CLEAR:      op.clear      = 1'b1;
				default:        op.clear      = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			refused_q   <= 1'b0;
			count_q     <= '0;
		end else begin
			if (accept) begin
				rsp_valid_q <= 1'b1;
				refused_q   <= full && (req.action == ACT_PUSH_FRONT
					|| req.action == ACT_PUSH_BACK);
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (op.clear) begin
				count_q <= '0;
			end else if (op.push_front || op.push_back) begin
				count_q <= count_q + COUNT_W'(1);
			end else if (op.pop_front || op.pop_back) begin
				count_q <= count_q - COUNT_W'(1);
			end
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t f_left;
		word_t f_right;
		word_t r_left;
		word_t r_right;
		logic  valid_left;
		logic  valid_right;

		if (i == 0) begin : g_head
			assign f_left     = req.value;
			assign r_left     = req.value;
			assign valid_left = 1'b1;
		end else begin : g_mid
			assign f_left     = f_vec[i-1];
			assign r_left     = r_vec[i-1];
			assign valid_left = valid_vec[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign f_right     = '0;
			assign r_right     = '0;
			assign valid_right = 1'b0;
		end else begin : g_inner
			assign f_right     = f_vec[i+1];
			assign r_right     = r_vec[i+1];
			assign valid_right = valid_vec[i+1];
		end

		dq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.op          (op),
			.f_left      (f_left),
			.f_right     (f_right),
			.r_left      (r_left),
			.r_right     (r_right),
			.valid_left  (valid_left),
			.valid_right (valid_right),
			.f_q         (f_vec[i]),
			.r_q         (r_vec[i]),
			.valid_q     (valid_vec[i])
		);
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.front_value = valid_vec[0] ? f_vec[0] : '0;
	assign rsp.back_value  = valid_vec[0] ? r_vec[0] : '0;
	assign rsp.count       = count_q;
	assign rsp.refused     = refused_q;

	`DQ_ASSERT(a_count_bound, clk, arst_n, count_q <= COUNT_W'(DEPTH), "count beyond depth")
	`DQ_ASSERT(a_valid_count, clk, arst_n, $countones(valid_vec) == 32'(count_q), "valid cells differ from count")
	`DQ_ASSERT_IMP(a_refused_full, clk, arst_n, rsp_valid_q && refused_q, full, "refused while not full")
	`DQ_ASSERT_IMP(a_stall_hold, clk, arst_n, rsp_valid_q && !rsp.ready, ##1 $stable(count_q), "state moved under stall")

endmodule

`default_nettype wire

FILE: sv/dq_cell.sv
// ----------------------------------------------------------------------------
// dq_cell
// one slot of the queue: a front-ordered word, a back-ordered word, a valid bit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dq_cell
	import dq_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire dq_op_t op,
	input  wire word_t  f_left,
	input  wire word_t  f_right,
	input  wire word_t  r_left,
	input  wire word_t  r_right,
	input  wire logic   valid_left,
	input  wire logic   valid_right,
	output      word_t  f_q,
	output      word_t  r_q,
	output      logic   valid_q
);

	logic is_tail_slot;

	// first free slot of the chain
	assign is_tail_slot = !valid_q && valid_left;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op.clear) begin
			valid_q <= 1'b0;
		end else if (op.push_front || op.push_back) begin
			valid_q <= valid_left;
		end else if (op.pop_front || op.pop_back) begin
			valid_q <= valid_right;
		end
	end

	always_ff @(posedge clk) begin
		if (op.push_front) begin
			f_q <= f_left;
			if (is_tail_slot) begin
				r_q <= op.value;
			end
		end else if (op.push_back) begin
			r_q <= r_left;
			if (is_tail_slot) begin
				f_q <= op.value;
			end
		end else if (op.pop_front) begin
			f_q <= f_right;
		end else if (op.pop_back) begin
			r_q <= r_right;
		end
	end

endmodule

`default_nettype wire
